@@ src/pts_pkg.sv @@
// Package: shared types and codes of the priority task scheduler.
`timescale 1ns / 1ps
`default_nettype none
package pts_pkg;

   // Number of task slots; slot ids and current_task are 3 bits wide.
   localparam int NUM_TASKS = 8;

   typedef enum logic [1:0] {
      FUNC_CREATE = 2'd0,
      FUNC_SIGNAL = 2'd1,
      FUNC_WAIT   = 2'd2,
      FUNC_TICK   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_FREE    = 2'd0,
      ST_READY   = 2'd1,
      ST_RUNNING = 2'd2,
      ST_WAITING = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ERR_OK        = 2'd0,
      ERR_SLOT_BUSY = 2'd1,
      ERR_SLOT_FREE = 2'd2,
      ERR_NO_RUN    = 2'd3
   } err_type;

   typedef struct packed {
      func_type          func;
      logic [2:0]        task_id;
      logic [31:0]       sig_mask;
      logic signed [7:0] priority_req;
   } req_type;

   typedef struct packed {
      logic [2:0]  current_task;
      logic        current_valid;
      logic        blocked;
      logic        resumed;
      logic [31:0] received_bits;
      logic        woke_task;
      err_type     error_code;
   } rsp_type;

   // Per-slot record held in the task memory.
   typedef struct packed {
      status_type        status;
      logic signed [7:0] prio;
      logic [31:0]       received;
      logic [31:0]       awaited;
      logic              wake;
   } task_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_READ,
      S_DECIDE,
      S_RQ_READ,
      S_RQ_WAIT,
      S_RQ_CMP,
      S_INS_WRITE,
      S_SHIFT,
      S_POP_READ,
      S_POP_HEAD,
      S_POP_SHIFT,
      S_DISP_READ,
      S_DISP_MOD,
      S_RESP
   } state_type;

endpackage
`default_nettype wire

@@ src/priority_task_scheduler_with_signals.sv @@
// Top level: priority task scheduler with signal wait.
`timescale 1ns / 1ps
`default_nettype none
// Usage: drive req_data with start high while busy is low; the transaction is
// taken at that edge. One result per transaction appears on rsp_data for one
// cycle, marked by rsp_valid; the receiver cannot stall it.
// Task records live in a one-port task memory and the ready queue in a
// second memory, both with registered reads. Wait, a signal that wakes
// nothing, a tick on an empty queue and every error go from the record read
// straight to the result. Create and a waking signal first walk the ready
// queue to insert the slot in priority order, moving later entries up where
// needed. A tick re-queues a running current task in the same way, then pops
// the head and dispatches it. The queue walk does one queue read, one record
// read and one priority compare per entry. busy is high from acceptance until
// the result strobe, so the next transaction can be taken at the edge that
// ends the strobe.
// Reset clears status, counts and current task at once; task records carry a
// valid bit per slot so a slot never created reads as free with zero fields.
// Queue entries are read only below the count, so they need no clearing.
module priority_task_scheduler_with_signals (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   output logic                  busy,
   input  wire pts_pkg::req_type req_data,
   output logic                  rsp_valid,
   output pts_pkg::rsp_type      rsp_data
);
   localparam int IW = $clog2(pts_pkg::NUM_TASKS);
   localparam int CW = $clog2(pts_pkg::NUM_TASKS + 1);

   // Memories.
   pts_pkg::task_type tmem [pts_pkg::NUM_TASKS];
   logic [IW-1:0]     qmem [pts_pkg::NUM_TASKS];
   logic [pts_pkg::NUM_TASKS-1:0] tvalid_ff, tvalid_in;

   pts_pkg::state_type state_ff, state_in;
   pts_pkg::state_type ins_next;               // state after an insertion
   pts_pkg::req_type   req_ff, req_in;
   pts_pkg::task_type  rec_ff, rec_in;        // record being worked on
   logic [IW-1:0]      slot_ff, slot_in;      // slot of that record
   logic [CW-1:0]      cnt_ff, cnt_in;        // ready_count
   logic [IW-1:0]      cur_ff, cur_in;
   logic               pres_ff, pres_in;
   logic [CW-1:0]      pos_ff, pos_in;        // queue walk position
   pts_pkg::rsp_type   rsp_ff, rsp_in;
   logic               rv_ff, rv_in;

   // Memory ports.
   logic              t_we;
   logic [IW-1:0]     t_addr;
   pts_pkg::task_type t_wd, t_rd_raw, t_rd;
   logic              t_rvalid_ff;
   logic              q_we;
   logic [IW-1:0]     q_waddr, q_raddr, q_wd, q_rd;
   logic              id_ok;

   always_ff @(posedge clock) begin
      if (t_we) begin
         tmem[t_addr] <= t_wd;
      end
      t_rd_raw <= tmem[t_addr];
      t_rvalid_ff <= tvalid_ff[t_addr];
   end

   always_ff @(posedge clock) begin
      if (q_we) begin
         qmem[q_waddr] <= q_wd;
      end
      q_rd <= qmem[q_raddr];
   end

   // Read a never-created slot as free with zero fields.
   always_comb begin
      t_rd = t_rd_raw;
      if (!t_rvalid_ff) begin
         t_rd = '0;
      end
   end

   assign busy      = (state_ff != pts_pkg::S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

   assign id_ok    = ({1'b0, req_ff.task_id} < 4'(pts_pkg::NUM_TASKS));
   assign ins_next = (req_ff.func == pts_pkg::FUNC_TICK) ? pts_pkg::S_POP_READ
                                                         : pts_pkg::S_RESP;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pts_pkg::S_IDLE: begin
            if (start) begin
               state_in = pts_pkg::S_READ;
            end
         end
         pts_pkg::S_READ: begin
            state_in = pts_pkg::S_DECIDE;
         end
         pts_pkg::S_DECIDE: begin
            state_in = pts_pkg::S_RESP;
            unique case (req_ff.func)
               pts_pkg::FUNC_CREATE: begin
                  if (id_ok && t_rd.status == pts_pkg::ST_FREE) begin
                     state_in = pts_pkg::S_RQ_READ;
                  end
               end
               pts_pkg::FUNC_SIGNAL: begin
                  if (id_ok && t_rd.status == pts_pkg::ST_WAITING &&
                      ((t_rd.received | req_ff.sig_mask) & t_rd.awaited) != '0) begin
                     state_in = pts_pkg::S_RQ_READ;
                  end
               end
               pts_pkg::FUNC_WAIT: begin
                  state_in = pts_pkg::S_RESP;
               end
               pts_pkg::FUNC_TICK: begin
                  if (cnt_ff != '0) begin
                     if (pres_ff && t_rd.status == pts_pkg::ST_RUNNING) begin
                        state_in = pts_pkg::S_RQ_READ;
                     end else begin
                        state_in = pts_pkg::S_POP_READ;
                     end
                  end
               end
            endcase
         end
         pts_pkg::S_RQ_READ: begin
            if (cnt_ff >= CW'(pts_pkg::NUM_TASKS)) begin
               state_in = ins_next;
            end else if (pos_ff == cnt_ff) begin
               state_in = pts_pkg::S_INS_WRITE;
            end else begin
               state_in = pts_pkg::S_RQ_WAIT;
            end
         end
         pts_pkg::S_RQ_WAIT: begin
            state_in = pts_pkg::S_RQ_CMP;
         end
         pts_pkg::S_RQ_CMP: begin
            if (t_rd.prio >= rec_ff.prio) begin
               state_in = pts_pkg::S_RQ_READ;
            end else begin
               state_in = pts_pkg::S_SHIFT;
            end
         end
         pts_pkg::S_INS_WRITE: begin
            state_in = ins_next;
         end
         pts_pkg::S_SHIFT: begin
            if (pos_ff == cnt_ff) begin
               state_in = ins_next;
            end
         end
         pts_pkg::S_POP_READ: begin
            state_in = pts_pkg::S_POP_HEAD;
         end
         pts_pkg::S_POP_HEAD: begin
            state_in = pts_pkg::S_POP_SHIFT;
         end
         pts_pkg::S_POP_SHIFT: begin
            if (pos_ff >= cnt_ff) begin
               state_in = pts_pkg::S_DISP_READ;
            end
         end
         pts_pkg::S_DISP_READ: begin
            state_in = pts_pkg::S_DISP_MOD;
         end
         pts_pkg::S_DISP_MOD: begin
            state_in = pts_pkg::S_RESP;
         end
         pts_pkg::S_RESP: begin
            state_in = pts_pkg::S_IDLE;
         end
         default: begin
            state_in = pts_pkg::S_IDLE;
         end
      endcase
   end

   // Data path and memory ports.
   always_comb begin
      req_in    = req_ff;
      rec_in    = rec_ff;
      slot_in   = slot_ff;
      cnt_in    = cnt_ff;
      cur_in    = cur_ff;
      pres_in   = pres_ff;
      pos_in    = pos_ff;
      rsp_in    = rsp_ff;
      rv_in     = 1'b0;
      tvalid_in = tvalid_ff;
      t_we      = 1'b0;
      t_addr    = slot_ff;
      t_wd      = rec_ff;
      q_we      = 1'b0;
      q_waddr   = pos_ff[IW-1:0];
      q_raddr   = pos_ff[IW-1:0];
      q_wd      = slot_ff;
      unique case (state_ff)
         pts_pkg::S_IDLE: begin
            if (start) begin
               req_in = req_data;
               rsp_in = '0;
            end
         end
         pts_pkg::S_READ: begin
            // Address the slot that this transaction concerns.
            if (req_ff.func == pts_pkg::FUNC_CREATE || req_ff.func == pts_pkg::FUNC_SIGNAL) begin
               slot_in = req_ff.task_id[IW-1:0];
            end else begin
               slot_in = cur_ff;
            end
            t_addr = slot_in;
         end
         pts_pkg::S_DECIDE: begin
            rec_in = t_rd;
            pos_in = '0;
            unique case (req_ff.func)
               pts_pkg::FUNC_CREATE: begin
                  if (!id_ok || t_rd.status != pts_pkg::ST_FREE) begin
                     rsp_in.error_code = pts_pkg::ERR_SLOT_BUSY;
                  end else begin
                     rec_in.status = pts_pkg::ST_READY;
                     rec_in.prio = req_ff.priority_req;
                     rec_in.received = '0;
                     rec_in.awaited = '0;
                     rec_in.wake = 1'b0;
                     t_we = 1'b1;
                     t_wd = rec_in;
                     tvalid_in[slot_ff] = 1'b1;
                  end
               end
               pts_pkg::FUNC_SIGNAL: begin
                  if (!id_ok || t_rd.status == pts_pkg::ST_FREE) begin
                     rsp_in.error_code = pts_pkg::ERR_SLOT_FREE;
                  end else begin
                     rec_in.received = t_rd.received | req_ff.sig_mask;
                     if ((rec_in.received & t_rd.awaited) != '0 &&
                         t_rd.status == pts_pkg::ST_WAITING) begin
                        rec_in.status = pts_pkg::ST_READY;
                        rec_in.wake = 1'b1;
                        rsp_in.woke_task = 1'b1;
                     end
                     t_we = 1'b1;
                     t_wd = rec_in;
                  end
               end
               pts_pkg::FUNC_WAIT: begin
                  if (!pres_ff || t_rd.status != pts_pkg::ST_RUNNING) begin
                     rsp_in.error_code = pts_pkg::ERR_NO_RUN;
                  end else if ((t_rd.received & req_ff.sig_mask) != '0) begin
                     rsp_in.received_bits = t_rd.received & req_ff.sig_mask;
                     rec_in.received = t_rd.received & ~req_ff.sig_mask;
                     t_we = 1'b1;
                     t_wd = rec_in;
                  end else begin
                     rec_in.awaited = req_ff.sig_mask;
                     rec_in.status = pts_pkg::ST_WAITING;
                     rsp_in.blocked = 1'b1;
                     t_we = 1'b1;
                     t_wd = rec_in;
                  end
               end
               pts_pkg::FUNC_TICK: begin
                  // Re-queue a running current task before the pop.
                  if (cnt_ff != '0 && pres_ff && t_rd.status == pts_pkg::ST_RUNNING) begin
                     rec_in.status = pts_pkg::ST_READY;
                     t_we = 1'b1;
                     t_wd = rec_in;
                  end
               end
            endcase
         end
         // Sorted insertion: walk past entries of equal or higher priority.
         pts_pkg::S_RQ_READ: begin
         end
         pts_pkg::S_RQ_WAIT: begin
            t_addr = q_rd;
         end
         pts_pkg::S_RQ_CMP: begin
            if (t_rd.prio >= rec_ff.prio) begin
               pos_in = pos_ff + 1'b1;
            end else begin
               // Store the new slot here; the old entry comes back on q_rd.
               q_we = 1'b1;
               pos_in = pos_ff + 1'b1;
            end
         end
         pts_pkg::S_INS_WRITE: begin
            q_we = 1'b1;
            cnt_in = cnt_ff + 1'b1;
         end
         // Ripple the tail up one place, one entry per cycle.
         pts_pkg::S_SHIFT: begin
            q_we = 1'b1;
            q_wd = q_rd;
            if (pos_ff == cnt_ff) begin
               cnt_in = cnt_ff + 1'b1;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         // Pop: take the head, shift the rest down.
         pts_pkg::S_POP_READ: begin
            q_raddr = '0;
            pos_in = CW'(1);
         end
         pts_pkg::S_POP_HEAD: begin
            slot_in = q_rd;
         end
         pts_pkg::S_POP_SHIFT: begin
            if (pos_ff < cnt_ff) begin
               q_we = 1'b1;
               q_waddr = IW'(pos_ff - 1'b1);
               q_wd = q_rd;
               pos_in = pos_ff + 1'b1;
               q_raddr = pos_in[IW-1:0];
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         pts_pkg::S_DISP_READ: begin
         end
         // Dispatch the head and hand back the bits of a completed wait.
         pts_pkg::S_DISP_MOD: begin
            rec_in = t_rd;
            rec_in.status = pts_pkg::ST_RUNNING;
            if (t_rd.wake) begin
               rec_in.wake = 1'b0;
               rec_in.received = t_rd.received & ~t_rd.awaited;
               rsp_in.received_bits = t_rd.received & t_rd.awaited;
               rsp_in.resumed = 1'b1;
            end
            t_we = 1'b1;
            t_wd = rec_in;
            cur_in = slot_ff;
            pres_in = 1'b1;
         end
         pts_pkg::S_RESP: begin
            rv_in = 1'b1;
            rsp_in.current_task = pres_ff ? 3'(cur_ff) : 3'd0;
            rsp_in.current_valid = pres_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= pts_pkg::S_IDLE;
         tvalid_ff <= '0;
         cnt_ff    <= '0;
         cur_ff    <= '0;
         pres_ff   <= 1'b0;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         tvalid_ff <= tvalid_in;
         cnt_ff    <= cnt_in;
         cur_ff    <= cur_in;
         pres_ff   <= pres_in;
         rv_ff     <= rv_in;
      end
      req_ff  <= req_in;
      rec_ff  <= rec_in;
      slot_ff <= slot_in;
      pos_ff  <= pos_in;
      rsp_ff  <= rsp_in;
   end

   // Assertions.
   a_count: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(pts_pkg::NUM_TASKS)) else $error("ready count overflow");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> state_ff == pts_pkg::S_IDLE) else $error("result while busy");
   a_err: assert property (@(posedge clock) disable iff (reset)
      rv_ff && rsp_ff.error_code != pts_pkg::ERR_OK |-> !rsp_ff.blocked && !rsp_ff.woke_task)
      else $error("flags on error");
   a_idle_cur: assert property (@(posedge clock) disable iff (reset)
      !pres_ff |-> cur_ff == '0) else $error("current slot set while idle");
endmodule
`default_nettype wire

@@ verif/testbench.sv @@
// Testbench for the priority task scheduler: directed and random transactions checked by a predictor.
`timescale 1ns / 1ps
`default_nettype none
module testbench;

   localparam int NTASK = pts_pkg::NUM_TASKS;
   localparam int WATCHDOG_LIMIT = 4000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   pts_pkg::req_type req_data = '0;
   logic             rsp_valid;
   pts_pkg::rsp_type rsp_data;

   priority_task_scheduler_with_signals dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predicted scheduler state
   pts_pkg::status_type slot_status [NTASK];
   logic signed [7:0]   slot_prio [NTASK];
   logic [31:0]         slot_rcvd [NTASK];
   logic [31:0]         slot_await [NTASK];
   logic                slot_wake [NTASK];
   logic [2:0]          run_queue [$];
   logic [2:0]          cur_slot;
   logic                cur_present;

   pts_pkg::rsp_type expected_rsp [$];
   int      mismatch_count = 0;
   int      rsp_count = 0;
   int      idle_cycles = 0;
   bit      allow_idle = 1'b1;
   int      func_seen [4];
   int      blocked_seen = 0, resumed_seen = 0, woke_seen = 0;

   // Insert before the first entry of strictly lower priority.
   function automatic void enqueue_ready(input logic [2:0] slot);
      int pos;
      pos = 0;
      if (run_queue.size() >= NTASK) return;
      while (pos < run_queue.size() && slot_prio[run_queue[pos]] >= slot_prio[slot]) pos++;
      run_queue.insert(pos, slot);
   endfunction

   function automatic pts_pkg::rsp_type schedule_step(input pts_pkg::req_type r);
      pts_pkg::rsp_type o;
      logic [2:0]       id;
      o = '0;
      id = r.task_id;
      unique case (r.func)
         pts_pkg::FUNC_CREATE: begin
            if (slot_status[id] != pts_pkg::ST_FREE) begin
               o.error_code = pts_pkg::ERR_SLOT_BUSY;
            end else begin
               slot_prio[id] = r.priority_req;
               slot_rcvd[id] = '0;
               slot_await[id] = '0;
               slot_wake[id] = 1'b0;
               slot_status[id] = pts_pkg::ST_READY;
               enqueue_ready(id);
            end
         end
         pts_pkg::FUNC_SIGNAL: begin
            if (slot_status[id] == pts_pkg::ST_FREE) begin
               o.error_code = pts_pkg::ERR_SLOT_FREE;
            end else begin
               slot_rcvd[id] |= r.sig_mask;
               if ((slot_rcvd[id] & slot_await[id]) != 0 &&
                   slot_status[id] == pts_pkg::ST_WAITING) begin
                  slot_status[id] = pts_pkg::ST_READY;
                  slot_wake[id] = 1'b1;
                  enqueue_ready(id);
                  o.woke_task = 1'b1;
               end
            end
         end
         pts_pkg::FUNC_WAIT: begin
            if (!cur_present || slot_status[cur_slot] != pts_pkg::ST_RUNNING) begin
               o.error_code = pts_pkg::ERR_NO_RUN;
            end else if ((slot_rcvd[cur_slot] & r.sig_mask) != 0) begin
               o.received_bits = slot_rcvd[cur_slot] & r.sig_mask;
               slot_rcvd[cur_slot] &= ~r.sig_mask;
            end else begin
               slot_await[cur_slot] = r.sig_mask;
               slot_status[cur_slot] = pts_pkg::ST_WAITING;
               o.blocked = 1'b1;
            end
         end
         pts_pkg::FUNC_TICK: begin
            if (run_queue.size() > 0) begin
               if (cur_present && slot_status[cur_slot] == pts_pkg::ST_RUNNING) begin
                  slot_status[cur_slot] = pts_pkg::ST_READY;
                  enqueue_ready(cur_slot);
               end
               cur_slot = run_queue.pop_front();
               cur_present = 1'b1;
               slot_status[cur_slot] = pts_pkg::ST_RUNNING;
               if (slot_wake[cur_slot]) begin
                  slot_wake[cur_slot] = 1'b0;
                  o.received_bits = slot_rcvd[cur_slot] & slot_await[cur_slot];
                  slot_rcvd[cur_slot] &= ~slot_await[cur_slot];
                  o.resumed = 1'b1;
               end
            end
         end
      endcase
      o.current_task = cur_present ? cur_slot : 3'd0;
      o.current_valid = cur_present;
      return o;
   endfunction

   function automatic void clear_model();
      for (int i = 0; i < NTASK; i++) begin
         slot_status[i] = pts_pkg::ST_FREE;
         slot_prio[i] = '0;
         slot_rcvd[i] = '0;
         slot_await[i] = '0;
         slot_wake[i] = 1'b0;
      end
      run_queue.delete();
      cur_slot = '0;
      cur_present = 1'b0;
   endfunction

   // Send one transaction; predict its result at acceptance. start stays high
   // after acceptance so back-to-back calls drive it once per time step.
   task automatic send_request(input pts_pkg::func_type f, input logic [2:0] id,
                               input logic [31:0] mask, input logic signed [7:0] prio);
      pts_pkg::req_type r;
      int               gap;
      r.func = f;
      r.task_id = id;
      r.sig_mask = mask;
      r.priority_req = prio;
      if (allow_idle && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 14);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_rsp.push_back(schedule_step(r));
      func_seen[f]++;
   endtask

   // Check each result strobe against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         rsp_count++;
         if (rsp_data.blocked) blocked_seen++;
         if (rsp_data.resumed) resumed_seen++;
         if (rsp_data.woke_task) woke_seen++;
         if (expected_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result %h", rsp_data);
         end else if (expected_rsp[0] != rsp_data) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("mismatch: expected %p actual %p", expected_rsp[0], rsp_data);
            void'(expected_rsp.pop_front());
         end else begin
            void'(expected_rsp.pop_front());
         end
      end
   end

   // Watchdog: count cycles with nothing accepted and no result.
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired");
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Field extremes, errors on create, signal and wait, and sorted insertion order.
   task automatic test_directed();
      send_request(pts_pkg::FUNC_WAIT, 3'd0, 32'hFFFF_FFFF, 8'sd0);
      send_request(pts_pkg::FUNC_TICK, 3'd0, 32'h0, 8'sd0);
      send_request(pts_pkg::FUNC_SIGNAL, 3'd7, 32'hFFFF_FFFF, 8'sd0);
      send_request(pts_pkg::FUNC_CREATE, 3'd0, 32'h0, -8'sd128);
      send_request(pts_pkg::FUNC_CREATE, 3'd7, 32'hFFFF_FFFF, 8'sd127);
      send_request(pts_pkg::FUNC_CREATE, 3'd3, 32'h0, 8'sd127);
      send_request(pts_pkg::FUNC_CREATE, 3'd7, 32'h0, 8'sd5);
      send_request(pts_pkg::FUNC_WAIT, 3'd0, 32'h1, 8'sd0);
      send_request(pts_pkg::FUNC_TICK, 3'd0, 32'h0, 8'sd0);
      send_request(pts_pkg::FUNC_SIGNAL, 3'd7, 32'h8000_0001, 8'sd0);
      send_request(pts_pkg::FUNC_WAIT, 3'd0, 32'h0000_0001, 8'sd0);
      send_request(pts_pkg::FUNC_WAIT, 3'd0, 32'h0000_0001, 8'sd0);
      send_request(pts_pkg::FUNC_SIGNAL, 3'd7, 32'h0000_0002, 8'sd0);
      send_request(pts_pkg::FUNC_TICK, 3'd0, 32'h0, 8'sd0);
      send_request(pts_pkg::FUNC_SIGNAL, 3'd7, 32'h0000_0001, 8'sd0);
      send_request(pts_pkg::FUNC_TICK, 3'd0, 32'h0, 8'sd0);
      send_request(pts_pkg::FUNC_TICK, 3'd0, 32'h0, 8'sd0);
      send_request(pts_pkg::FUNC_WAIT, 3'd0, 32'h0, 8'sd0);
      send_request(pts_pkg::FUNC_SIGNAL, 3'd3, 32'hFFFF_FFFF, 8'sd0);
      send_request(pts_pkg::FUNC_TICK, 3'd0, 32'h0, 8'sd0);
      send_request(pts_pkg::FUNC_TICK, 3'd0, 32'h0, 8'sd0);
   endtask

   // Mostly plausible scheduling traffic with narrow masks so waits both block and wake.
   task automatic test_random(input int count, input bit with_idle);
      int          pick;
      logic [31:0] mask;
      allow_idle = with_idle;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         case ($urandom_range(0, 3))
            0: mask = $urandom();
            1: mask = 32'h0;
            default: mask = 32'h1 << $urandom_range(0, 3);
         endcase
         if (pick < 12)
            send_request(pts_pkg::FUNC_CREATE, 3'($urandom_range(0, 7)), $urandom(),
                         8'($urandom()));
         else if (pick < 45)
            send_request(pts_pkg::FUNC_SIGNAL, 3'($urandom_range(0, 7)), mask,
                         8'($urandom()));
         else if (pick < 70)
            send_request(pts_pkg::FUNC_WAIT, 3'($urandom_range(0, 7)), mask,
                         8'($urandom()));
         else
            send_request(pts_pkg::FUNC_TICK, 3'($urandom_range(0, 7)), $urandom(),
                         8'($urandom()));
      end
   endtask

   task automatic wait_for_drain();
      int guard;
      guard = 0;
      start <= 1'b0;
      while (expected_rsp.size() != 0 && guard < WATCHDOG_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (60) @(posedge clock);
   endtask

   initial begin
      clear_model();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(1000, 1'b1);
      test_random(330, 1'b0);
      wait_for_drain();
      $display("covered %0d create, %0d signal, %0d wait, %0d tick transactions",
               func_seen[0], func_seen[1], func_seen[2], func_seen[3]);
      $display("%0d results: %0d blocked, %0d woken, %0d resumed, %0d mismatches",
               rsp_count, blocked_seen, woke_seen, resumed_seen, mismatch_count);
      if (mismatch_count == 0 && expected_rsp.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire

@@ filelist.f @@
src/pts_pkg.sv
src/priority_task_scheduler_with_signals.sv
verif/testbench.sv
